@@ hw/rtl/u8f_pkg.sv @@
// u8f_pkg: shared types and constants of the 8N1 UART with FIFOs.
// Holds the item and result beat layouts and the action codes.
// No dependencies.
package u8f_pkg;

    // Action codes of an item beat
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_PUSH = 2'd1;
    localparam logic [1:0] ACT_POP  = 2'd2;

    // Bit timing: 104 one-microsecond ticks is 9600 baud
    localparam logic [15:0] BIT_TICKS_RESET = 16'(1000000 / 9600);

    // Frame layout: eight data bits, then the stop bit
    localparam logic [3:0] DATA_BITS  = 4'd8;
    localparam logic [3:0] FRAME_BITS = 4'd9;
    localparam logic       STOP_LEVEL = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] tx_data;
        logic       rx_line;
    } item_t;

    typedef struct packed {
        logic       tx_line;
        logic [7:0] rx_data;
        logic       rx_data_valid;
        logic       rx_readable;
        logic       tx_busy;
        logic       tx_overflow;
        logic       rx_overrun;
    } result_t;

endpackage

@@ hw/rtl/u8f_chan_if.sv @@
// u8f_chan_if: valid/ready channel carrying one payload per beat.
// Payload type is a parameter; used with the types of u8f_pkg.
interface u8f_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/uart_8n1_with_fifos.sv @@
// uart_8n1_with_fifos: 8N1 UART transceiver with transmit and receive FIFOs.
// Depends on u8f_pkg (types, codes) and u8f_chan_if (channels).
//
//  channel | dir  | payload               | notes
//  --------+------+-----------------------+-------------------------------
//  req     | in   | u8f_pkg::item_t       | tick / push byte / pop byte
//  rsp     | out  | u8f_pkg::result_t     | one result beat per item beat
//  cfg     | in   | logic [15:0]          | bit_ticks, always ready
//
// One item per clock sustained while rsp is ready; each item passes
// the item register, then the result register; its UART work lies between.
// rsp stalls hold the result register and the item register; req stays ready
// while the item register is empty. Reset clears all control state at once;
// FIFO memories are not cleared, the fill counts guard every read.
module uart_8n1_with_fifos #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    u8f_chan_if.sink   req,
    u8f_chan_if.source rsp,
    u8f_chan_if.sink   cfg
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(FIFO_DEPTH);

    // Pointer advance with wrap at any depth
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] r;
        r = (ptr == LAST_PTR) ? '0 : ptr + AW'(1);
        return r;
    endfunction

    // Pipeline registers
    logic               in_valid_reg;
    u8f_pkg::item_t     item_reg;
    logic               rsp_valid_reg;
    u8f_pkg::result_t   rsp_data_reg;
    logic               advance;
    logic               do_step;

    // Configuration
    logic [15:0] bit_ticks_reg;
    logic [15:0] period;

    // FIFO storage and heads
    logic [7:0] tx_mem [FIFO_DEPTH];
    logic [7:0] rx_mem [FIFO_DEPTH];
    logic [7:0] tx_head_reg;
    logic [7:0] rx_head_reg;

    // FIFO control
    logic [AW-1:0] tx_rp_reg, tx_rp_next, tx_wp_reg, tx_wp_next;
    logic [FW-1:0] tx_fill_reg, tx_fill_next;
    logic [AW-1:0] rx_rp_reg, rx_rp_next, rx_wp_reg, rx_wp_next;
    logic [FW-1:0] rx_fill_reg, rx_fill_next;
    logic          tx_we, rx_we;
    logic [AW-1:0] tx_rd_addr, rx_rd_addr;

    // Transmit engine
    logic        tx_active_reg, tx_active_next;
    logic [8:0]  tx_shift_reg, tx_shift_next;
    logic [3:0]  tx_bits_reg, tx_bits_next;
    logic [15:0] tx_cd_reg, tx_cd_next, tx_cd_dec;
    logic        tx_level_reg, tx_level_next;
    logic        tx_start;
    logic [7:0]  tx_start_byte;

    // Receive engine
    logic        rx_active_reg, rx_active_next;
    logic [3:0]  rx_idx_reg, rx_idx_next;
    logic [7:0]  rx_shift_reg, rx_shift_next;
    logic [16:0] rx_cd_reg, rx_cd_next, rx_cd_dec;

    // Per-item result fields
    logic [7:0] popped;
    logic       pop_valid;
    logic       overflow;
    logic       overrun;

    // Handshakes
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign do_step   = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;
    assign cfg.ready = 1'b1;

    // Zero period counts as one
    assign period = (bit_ticks_reg == '0) ? 16'd1 : bit_ticks_reg;

    // Byte that a new frame takes: the pushed byte when the FIFO was empty
    assign tx_start_byte = (tx_fill_reg == '0) ? item_reg.tx_data : tx_head_reg;

    // Next state and result for the registered item
    always_comb
    begin
        tx_rp_next     = tx_rp_reg;
        tx_wp_next     = tx_wp_reg;
        tx_fill_next   = tx_fill_reg;
        rx_rp_next     = rx_rp_reg;
        rx_wp_next     = rx_wp_reg;
        rx_fill_next   = rx_fill_reg;
        tx_active_next = tx_active_reg;
        tx_shift_next  = tx_shift_reg;
        tx_bits_next   = tx_bits_reg;
        tx_cd_next     = tx_cd_reg;
        tx_level_next  = tx_level_reg;
        rx_active_next = rx_active_reg;
        rx_idx_next    = rx_idx_reg;
        rx_shift_next  = rx_shift_reg;
        rx_cd_next     = rx_cd_reg;
        tx_cd_dec      = (tx_cd_reg != '0) ? tx_cd_reg - 16'd1 : '0;
        rx_cd_dec      = (rx_cd_reg != '0) ? rx_cd_reg - 17'd1 : '0;
        tx_we          = 1'b0;
        rx_we          = 1'b0;
        tx_start       = 1'b0;
        popped         = '0;
        pop_valid      = 1'b0;
        overflow       = 1'b0;
        overrun        = 1'b0;

        unique case (item_reg.action)
            u8f_pkg::ACT_TICK:
            begin
                // Transmit bit timer
                if (tx_active_reg)
                begin
                    tx_cd_next = tx_cd_dec;
                    if (tx_cd_dec == '0)
                    begin
                        if (tx_bits_reg == '0)
                        begin
                            tx_level_next  = 1'b1;
                            tx_active_next = 1'b0;
                            tx_start       = (tx_fill_reg != '0);
                        end
                        else
                        begin
                            tx_level_next = tx_shift_reg[0];
                            tx_shift_next = {1'b0, tx_shift_reg[8:1]};
                            tx_bits_next  = tx_bits_reg - 4'd1;
                            tx_cd_next    = period;
                        end
                    end
                end
                // Receive: start detect, then bit sampling
                if (!rx_active_reg)
                begin
                    if (!item_reg.rx_line)
                    begin
                        rx_active_next = 1'b1;
                        rx_idx_next    = '0;
                        rx_shift_next  = '0;
                        rx_cd_next     = 17'(period) + 17'(period[15:1]);
                    end
                end
                else
                begin
                    rx_cd_next = rx_cd_dec;
                    if (rx_cd_dec == '0)
                    begin
                        if (rx_idx_reg < u8f_pkg::DATA_BITS)
                        begin
                            rx_shift_next[rx_idx_reg[2:0]] =
                                rx_shift_reg[rx_idx_reg[2:0]] | item_reg.rx_line;
                            rx_idx_next = rx_idx_reg + 4'd1;
                            rx_cd_next  = 17'(period);
                        end
                        else
                        begin
                            rx_active_next = 1'b0;
                            if (rx_fill_reg == FULL_FILL)
                            begin
                                overrun = 1'b1;
                            end
                            else
                            begin
                                rx_we        = 1'b1;
                                rx_wp_next   = ptr_inc(rx_wp_reg);
                                rx_fill_next = rx_fill_reg + FW'(1);
                            end
                        end
                    end
                end
            end
            u8f_pkg::ACT_PUSH:
            begin
                if (tx_fill_reg == FULL_FILL)
                begin
                    overflow = 1'b1;
                end
                else
                begin
                    tx_we        = 1'b1;
                    tx_wp_next   = ptr_inc(tx_wp_reg);
                    tx_fill_next = tx_fill_reg + FW'(1);
                end
                tx_start = !tx_active_reg && (tx_fill_next != '0);
            end
            u8f_pkg::ACT_POP:
            begin
                if (rx_fill_reg != '0)
                begin
                    popped       = rx_head_reg;
                    pop_valid    = 1'b1;
                    rx_rp_next   = ptr_inc(rx_rp_reg);
                    rx_fill_next = rx_fill_reg - FW'(1);
                end
            end
            default:
            begin
                // unused code: state unchanged, status reported
            end
        endcase

        // Start the next queued frame with its start bit
        if (tx_start)
        begin
            tx_rp_next     = ptr_inc(tx_rp_reg);
            tx_fill_next   = tx_fill_next - FW'(1);
            tx_shift_next  = {u8f_pkg::STOP_LEVEL, tx_start_byte};
            tx_bits_next   = u8f_pkg::FRAME_BITS;
            tx_active_next = 1'b1;
            tx_level_next  = 1'b0;
            tx_cd_next     = period;
        end
    end

    // FIFO head read addresses follow the read pointers
    assign tx_rd_addr = do_step ? tx_rp_next : tx_rp_reg;
    assign rx_rd_addr = do_step ? rx_rp_next : rx_rp_reg;

    // Transmit FIFO memory; head register bypasses a same-address write
    always_ff @(posedge clk)
    begin
        if (do_step && tx_we)
        begin
            tx_mem[tx_wp_reg] <= item_reg.tx_data;
        end
        if (do_step && tx_we && (tx_wp_reg == tx_rd_addr))
        begin
            tx_head_reg <= item_reg.tx_data;
        end
        else
        begin
            tx_head_reg <= tx_mem[tx_rd_addr];
        end
    end

    // Receive FIFO memory; head register bypasses a same-address write
    always_ff @(posedge clk)
    begin
        if (do_step && rx_we)
        begin
            rx_mem[rx_wp_reg] <= rx_shift_reg;
        end
        if (do_step && rx_we && (rx_wp_reg == rx_rd_addr))
        begin
            rx_head_reg <= rx_shift_reg;
        end
        else
        begin
            rx_head_reg <= rx_mem[rx_rd_addr];
        end
    end

    // Item and result payload registers
    always_ff @(posedge clk)
    begin
        if (req.ready)
        begin
            item_reg <= req.data;
        end
        if (do_step)
        begin
            rsp_data_reg.tx_line       <= tx_level_next;
            rsp_data_reg.rx_data       <= popped;
            rsp_data_reg.rx_data_valid <= pop_valid;
            rsp_data_reg.rx_readable   <= (rx_fill_next != '0);
            rsp_data_reg.tx_busy       <= tx_active_next;
            rsp_data_reg.tx_overflow   <= overflow;
            rsp_data_reg.rx_overrun    <= overrun;
        end
    end

    // Control and UART state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            bit_ticks_reg <= u8f_pkg::BIT_TICKS_RESET;
            tx_rp_reg     <= '0;
            tx_wp_reg     <= '0;
            tx_fill_reg   <= '0;
            rx_rp_reg     <= '0;
            rx_wp_reg     <= '0;
            rx_fill_reg   <= '0;
            tx_active_reg <= 1'b0;
            tx_shift_reg  <= '0;
            tx_bits_reg   <= '0;
            tx_cd_reg     <= '0;
            tx_level_reg  <= 1'b1;
            rx_active_reg <= 1'b0;
            rx_idx_reg    <= '0;
            rx_shift_reg  <= '0;
            rx_cd_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                bit_ticks_reg <= cfg.data;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= in_valid_reg;
            end
            if (do_step)
            begin
                tx_rp_reg     <= tx_rp_next;
                tx_wp_reg     <= tx_wp_next;
                tx_fill_reg   <= tx_fill_next;
                rx_rp_reg     <= rx_rp_next;
                rx_wp_reg     <= rx_wp_next;
                rx_fill_reg   <= rx_fill_next;
                tx_active_reg <= tx_active_next;
                tx_shift_reg  <= tx_shift_next;
                tx_bits_reg   <= tx_bits_next;
                tx_cd_reg     <= tx_cd_next;
                tx_level_reg  <= tx_level_next;
                rx_active_reg <= rx_active_next;
                rx_idx_reg    <= rx_idx_next;
                rx_shift_reg  <= rx_shift_next;
                rx_cd_reg     <= rx_cd_next;
            end
        end
    end

endmodule
